// ===== design/hsmpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsmpd_pkg
// shared widths, defaults and word types of the max pair distance block
// ----------------------------------------------------------------------------
package hsmpd_pkg;

   localparam int IN_W           = 16;
   localparam int DIST_W         = 17;
   localparam int DEF_MAX_HITS   = 256;
   localparam int DEF_COORD_BITS = 16;

   typedef struct packed {
      logic signed [IN_W-1:0] pos_x;
      logic signed [IN_W-1:0] pos_y;
      logic signed [IN_W-1:0] pos_z;
      logic                   hit_present;
      logic                   event_end;
   } req_word_type;

   typedef struct packed {
      logic [DIST_W-1:0] max_distance;
      logic              distance_nonzero;
      logic              hits_dropped;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== design/hsmpd_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsmpd_req_if
// valid/ready channel carrying one hit word
// ----------------------------------------------------------------------------
interface hsmpd_req_if
   import hsmpd_pkg::*;
   ();

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface
`default_nettype wire

// ===== design/hsmpd_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsmpd_rsp_if
// valid/ready channel carrying one event result word
// ----------------------------------------------------------------------------
interface hsmpd_rsp_if
   import hsmpd_pkg::*;
   ();

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface
`default_nettype wire

// ===== design/hit_set_max_pair_distance_top.sv =====
// a hit word with hits already stored is compared against each of them by the scan, which reads
// one stored hit per cycle from the store into the distance pipe; the pipe drains before the hit is written
// a closing word then runs the bit-serial square root and issues the result
// words are taken one at a time: a new word is accepted only once the last one is through
// reset: synchronous; clears count, best distance, overflow flag and control,
// the hit store needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hit_set_max_pair_distance_top
// stores the hits of one event and keeps the largest squared pair distance,
// then returns its floor square root on the closing word
// ----------------------------------------------------------------------------
module hit_set_max_pair_distance_top
   import hsmpd_pkg::*;
#(
   parameter int MAX_HITS   = DEF_MAX_HITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hsmpd_req_if.sink  req_chan,
   hsmpd_rsp_if.source rsp_chan
);

   localparam int ADDR_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CNT_W  = $clog2(MAX_HITS + 1);
   localparam int HIT_W  = 3 * COORD_BITS;
   localparam int SQP_W  = 2 * COORD_BITS;
   localparam int SQ_W   = SQP_W + 2;
   localparam int ROOT_W = COORD_BITS + 1;
   localparam int REM_W  = ROOT_W + 2;
   localparam int RC_W   = $clog2(ROOT_W);
   localparam int CMIN   = -(2 ** (COORD_BITS - 1));
   localparam int CMAX   = (2 ** (COORD_BITS - 1)) - 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_ROOT  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [IN_W-1:0] raw
   );
      int v;
      v = int'(raw);
      if (v < CMIN) v = CMIN;
      if (v > CMAX) v = CMAX;
      return COORD_BITS'(v);
   endfunction

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [SQ_W-1:0]       best_ff, best_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, last_in;
   logic [HIT_W-1:0]      hit_ff, hit_in;
   logic [3:0]            pipe_vld_ff, pipe_vld_in;
   logic [HIT_W-1:0]      mem_rd_ff;
   logic [COORD_BITS-1:0] mag_ff [3];
   logic [COORD_BITS-1:0] mag_in [3];
   logic [SQP_W-1:0]      sq_ff [3];
   logic [SQP_W-1:0]      sq_in [3];
   logic [SQ_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]       n_ff, n_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [RC_W-1:0]       rcnt_ff, rcnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                  rd_en;
   logic                  wr_en;
   logic                  load;
   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      trial;

   logic [HIT_W-1:0] mem [MAX_HITS];

   // hit store, one port each for read and write, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= hit_ff;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[idx_ff[ADDR_W-1:0]];
      end
   end

   // distance pipeline: magnitude, square, sum
   always_comb begin
      logic signed [COORD_BITS:0] d;
      logic signed [COORD_BITS-1:0] a;
      logic signed [COORD_BITS-1:0] b;
      for (int i = 0; i < 3; i++) begin
         a = hit_ff[HIT_W-1-i*COORD_BITS -: COORD_BITS];
         b = mem_rd_ff[HIT_W-1-i*COORD_BITS -: COORD_BITS];
         d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
         mag_in[i] = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
         sq_in[i]  = SQP_W'(mag_ff[i]) * SQP_W'(mag_ff[i]);
      end
      sum_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
   end

   assign pipe_vld_in = {pipe_vld_ff[2:0], rd_en};

   // square root step, two bits of the radicand per cycle
   assign rem_shift = {rem_ff[REM_W-3:0], n_ff[SQ_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rcnt_in      = rcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      load         = 1'b0;

      if (pipe_vld_ff[3] && (sum_ff > best_ff)) begin
         best_in = sum_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               last_in = req_chan.data.event_end;
               hit_in  = {sat_coord(req_chan.data.pos_x),
                          sat_coord(req_chan.data.pos_y),
                          sat_coord(req_chan.data.pos_z)};
               if (req_chan.data.hit_present && (count_ff < CNT_W'(MAX_HITS))) begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  if (req_chan.data.hit_present) begin
                     ovf_in = 1'b1;
                  end
                  if (req_chan.data.event_end) begin
                     n_in     = best_ff;
                     rem_in   = '0;
                     root_in  = '0;
                     rcnt_in  = RC_W'(ROOT_W - 1);
                     state_in = ST_ROOT;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff != count_ff) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_vld_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (last_ff) begin
                  n_in     = best_ff;
                  rem_in   = '0;
                  root_in  = '0;
                  rcnt_in  = RC_W'(ROOT_W - 1);
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROOT: begin
            n_in = {n_ff[SQ_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rcnt_in = rcnt_ff - 1'b1;
            if (rcnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load                         = 1'b1;
               rsp_valid_in                 = 1'b1;
               rsp_word_in.max_distance     = DIST_W'(root_ff);
               rsp_word_in.distance_nonzero = (best_ff != '0);
               rsp_word_in.hits_dropped     = ovf_ff;
               count_in                     = '0;
               best_in                      = '0;
               ovf_in                       = 1'b0;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         pipe_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      hit_ff      <= hit_in;
      mag_ff      <= mag_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rcnt_ff     <= rcnt_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

`ifndef SYNTHESIS
   // distance pipeline only busy while the store is being scanned or the pipe drained
   assert property (@(posedge clock) disable iff (reset)
      (pipe_vld_ff != '0) |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("distance pipeline active outside scan");

   // a hit is stored only when there is room
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CNT_W'(MAX_HITS)))
      else $error("hit store written when full");

   // issuing a result clears the event state
   assert property (@(posedge clock) disable iff (reset)
      load |=> ((count_ff == '0) && (best_ff == '0) && !ovf_ff && rsp_chan.valid))
      else $error("event state not cleared after result");
`endif

endmodule
`default_nettype wire
